// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define ASSERT_NEVER(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_NEVER(name, expr, msg)
`endif
`endif

// ===== hdl/sli_pkg.sv =====
// types and constants of the sorted list block
`default_nettype none
package sli_pkg;

   localparam int LIST_DEPTH_DEF = 16;
   localparam int OPCODE_W       = 2;
   localparam int VALUE_W        = 8;
   localparam int STATUS_W       = 3;
   localparam int COUNT_W        = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_DUMP   = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_DELETED  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_ELEMENT  = 3'd5
   } status_type;

   // what every cell does on the coming edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type               cmd;
      logic signed [VALUE_W-1:0]  value;
   } cell_ctl_type;

   typedef struct packed {
      logic gt;     // key is above this occupied entry
      logic match;  // occupied entry equals the key
   } cell_flags_type;

endpackage
`default_nettype wire

// ===== hdl/sli_if.sv =====
// request and response channel interfaces
`default_nettype none
interface sli_req_if import sli_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sli_rsp_if import sli_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  item;
   logic                       last;
   logic [COUNT_W-1:0]         entry_count;

   modport source (output valid, output status, output item, output last,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input item, input last,
                   input entry_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/sli_cell.sv =====
// one list cell: holds an entry, compares it with the key, shifts with its neighbors
`default_nettype none
module sli_cell import sli_pkg::*; (
   input  wire logic                       clock,
   input  wire cell_ctl_type               ctl,
   input  wire logic                       occupied,
   input  wire logic                       tail,
   input  wire logic                       prev_gt,
   input  wire logic signed [VALUE_W-1:0]  prev_entry,
   input  wire logic signed [VALUE_W-1:0]  next_entry,
   input  wire logic signed [VALUE_W-1:0]  head_entry,
   output cell_flags_type                  flags,
   output logic signed [VALUE_W-1:0]       entry
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   // compare against the broadcast key
   assign flags.gt    = occupied && (ctl.value > entry_ff);
   assign flags.match = occupied && (ctl.value == entry_ff);
   assign entry       = entry_ff;

   // next entry from own, key, neighbor or head entry
   always_comb begin
      entry_in = entry_ff;
      case (ctl.cmd)
         CELL_INSERT: begin
            if (!flags.gt) begin
               entry_in = prev_gt ? ctl.value : prev_entry;
            end
         end
         CELL_DELETE: begin
            if (!flags.gt) begin
               entry_in = next_entry;
            end
         end
         CELL_ROTATE: begin
            entry_in = tail ? head_entry : next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ===== hdl/sorted_list_insert_delete.sv =====
// top level of the sorted list: cell chain, fill count and response control
//
// Keeps up to LIST_DEPTH signed bytes in ascending order in a chain of cells.
// req carries opcode and value; rsp carries status, item, last and entry_count.
// Insert, delete, and dump of an empty list give one word each; insert and
// delete are done in the cycle the request is taken, all cells comparing and
// shifting at once, and their word shows on rsp the next cycle. A new request
// can be taken every cycle while rsp is taken.
// Dump rotates the chain one cell per cycle after the request cycle, sending
// the head entry each time; the first word is registered in the dump state,
// and a list of N entries gives N words, one per cycle, the final one with
// last set, so req is blocked until the final word is registered. The
// chain is back in its order afterwards. Opcode three is dropped with no word.
// When rsp stalls, the held word stays, the dump rotation pauses and req is
// not ready; nothing is lost.
// Reset empties the list; cell contents need no clearing.
`include "assert_macros.svh"
`default_nettype none
module sorted_list_insert_delete import sli_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sli_req_if.sink    req,
   sli_rsp_if.source  rsp
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           dump_idx_ff, dump_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_item_ff, rsp_item_in;
   logic                       rsp_last_ff, rsp_last_in;

   cell_ctl_type               ctl;
   cell_flags_type             flags [LIST_DEPTH];
   logic signed [VALUE_W-1:0]  entry [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]      match_vec;
   logic                       out_free;
   logic                       accept;
   logic                       found;
   logic                       full;
   logic                       dump_last;
   logic                       insert_taken;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   assign found     = |match_vec;
   assign full      = (count_ff == CNT_W'(LIST_DEPTH));
   assign dump_last = (dump_idx_ff == count_ff - CNT_W'(1));

   assign insert_taken = accept && (req.opcode == OP_INSERT) && !full;

   // cell chain
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic                      prev_gt;
      logic signed [VALUE_W-1:0] prev_entry;
      logic signed [VALUE_W-1:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_gt    = 1'b1;
         assign prev_entry = ctl.value;
      end else begin : g_inner
         assign prev_gt    = flags[i-1].gt;
         assign prev_entry = entry[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_end
         assign next_entry = entry[i];
      end else begin : g_mid
         assign next_entry = entry[i+1];
      end

      sli_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (CNT_W'(i) < count_ff),
         .tail       (count_ff == CNT_W'(i + 1)),
         .prev_gt    (prev_gt),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .head_entry (entry[0]),
         .flags      (flags[i]),
         .entry      (entry[i])
      );

      assign match_vec[i] = flags[i].match;
   end

   // operation decode and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.cmd       = CELL_HOLD;
      ctl.value     = req.value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_item_in = req.value;
               rsp_last_in = 1'b1;
               unique case (req.opcode)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.cmd       = CELL_INSERT;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = ST_INSERTED;
                     end
                  end
                  OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (found) begin
                        ctl.cmd       = CELL_DELETE;
                        count_in      = count_ff - CNT_W'(1);
                        rsp_status_in = ST_DELETED;
                     end else begin
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_item_in   = '0;
                     end else begin
                        state_in    = S_DUMP;
                        dump_idx_in = '0;
                     end
                  end
                  default: begin
                     rsp_item_in = rsp_item_ff;
                     rsp_last_in = rsp_last_ff;
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               ctl.cmd       = CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ELEMENT;
               rsp_item_in   = entry[0];
               rsp_last_in   = dump_last;
               dump_idx_in   = dump_idx_ff + CNT_W'(1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, fill count and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.item        = rsp_item_ff;
   assign rsp.last        = rsp_last_ff;
   assign rsp.entry_count = COUNT_W'(count_ff);

   // checks
   `ASSERT_NEVER(a_count_range, count_ff > CNT_W'(LIST_DEPTH), "fill count above depth")
   `ASSERT_CLK(a_insert_grows, insert_taken |=> count_ff == $past(count_ff) + CNT_W'(1), "no growth")
   `ASSERT_CLK(a_dump_stable, state_ff == S_DUMP |=> $stable(count_ff), "count moved in dump")

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking bench for the sorted list: corner items, output stalls and random mixes
`timescale 1ns / 1ps
module tb_top;
   import sli_pkg::*;

   localparam int DEPTH          = LIST_DEPTH_DEF;
   localparam int IDLE_PCT       = 16;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 2 * DEPTH + 8;
   localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  item;
      logic                       last;
      logic [COUNT_W-1:0]         entry_count;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset;

   // list contents as the block should hold them, and words still owed
   logic signed [VALUE_W-1:0] list_model[$];
   rsp_word_type              due_words[$];

   int error_count  = 0;
   int quiet_cycles = 0;
   bit steady       = 1'b0;
   bit hold_rsp     = 1'b0;

   sli_req_if req ();
   sli_rsp_if rsp ();

   sorted_list_insert_delete #(.LIST_DEPTH(DEPTH)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // queue one owed word, count taken after the list update
   function automatic void owe_word(status_type status, logic signed [VALUE_W-1:0] item,
                                    logic last);
      rsp_word_type w;
      w.status      = status;
      w.item        = item;
      w.last        = last;
      w.entry_count = COUNT_W'(list_model.size());
      due_words.push_back(w);
   endfunction

   // apply one accepted request to the list and owe its words
   function automatic void apply_request(logic [OPCODE_W-1:0] op,
                                         logic signed [VALUE_W-1:0] value);
      int pos;
      pos = 0;
      case (op)
         OP_INSERT: begin
            if (list_model.size() >= DEPTH) begin
               owe_word(ST_FULL, value, 1'b1);
            end else begin
               while (pos < list_model.size() && value > list_model[pos]) pos++;
               list_model.insert(pos, value);
               owe_word(ST_INSERTED, value, 1'b1);
            end
         end
         OP_DELETE: begin
            if (list_model.size() == 0) begin
               owe_word(ST_EMPTY, value, 1'b1);
            end else begin
               while (pos < list_model.size() && list_model[pos] != value) pos++;
               if (pos >= list_model.size()) begin
                  owe_word(ST_NOTFOUND, value, 1'b1);
               end else begin
                  list_model.delete(pos);
                  owe_word(ST_DELETED, value, 1'b1);
               end
            end
         end
         OP_DUMP: begin
            if (list_model.size() == 0) begin
               owe_word(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_model.size(); i++)
                  owe_word(ST_ELEMENT, list_model[i], i == list_model.size() - 1);
            end
         end
         default: ;
      endcase
   endfunction

   // offer one request word from a falling edge, return at the falling edge after it is taken
   task automatic send_word(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] value);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.opcode <= op;
      req.value  <= value;
      do @(posedge clock); while (!req.ready);
      apply_request(op, value);
      @(negedge clock);
   endtask

   // stop offering and wait until every owed word has come back
   task automatic drain_words;
      req.valid <= 1'b0;
      do @(negedge clock); while (due_words.size() != 0);
   endtask

   // pick a held value most of the time so deletes hit
   function automatic logic signed [VALUE_W-1:0] held_or_random;
      if (list_model.size() > 0 && $urandom_range(99) < 70)
         return list_model[$urandom_range(list_model.size() - 1)];
      return VALUE_W'($urandom_range(255));
   endfunction

   // empty list cases, extremes, duplicates, ignored opcode, full list
   task automatic test_corner_cases;
      send_word(OP_DUMP, 8'sd0);
      send_word(OP_DELETE, -8'sd128);
      send_word(OP_INSERT, 8'sd127);
      send_word(OP_INSERT, -8'sd128);
      send_word(OP_INSERT, 8'sd0);
      send_word(OP_INSERT, 8'sd0);
      send_word(OP_DELETE, 8'sd5);
      send_word(OP_DELETE, 8'sd0);
      send_word(OP_IGNORED, -8'sd1);
      send_word(OP_DUMP, -8'sd1);
      for (int i = 0; i < DEPTH - 3; i++) send_word(OP_INSERT, VALUE_W'(i * 19 - 90));
      send_word(OP_INSERT, 8'sd85);
      send_word(OP_DUMP, 8'sd0);
   endtask

   // hold rsp for a long stretch while requests keep coming
   task automatic test_input_stall;
      hold_rsp = 1'b1;
      steady   = 1'b1;
      for (int k = 0; k < 24; k++) begin
         if (k % 2 == 0) send_word(OP_DELETE, held_or_random());
         else send_word(OP_INSERT, VALUE_W'($urandom_range(255)));
      end
      steady = 1'b0;
   endtask

   // random mix steered toward a moving fill target so both empty and full are reached
   task automatic test_random_mix(int n_items);
      int                        sent;
      int                        target;
      logic [OPCODE_W-1:0]       op;
      logic signed [VALUE_W-1:0] value;
      sent   = 0;
      target = $urandom_range(DEPTH);
      while (sent < n_items) begin
         if (sent % 40 == 39) target = $urandom_range(DEPTH);
         case ($urandom_range(99)) inside
            [0:2]:   op = OP_IGNORED;
            [3:11]:  op = OP_DUMP;
            default: op = ($urandom_range(99) < ((list_model.size() < target) ? 75 : 30)) ?
                          OP_INSERT : OP_DELETE;
         endcase
         if (op == OP_DELETE && list_model.size() > 0 && $urandom_range(99) < 70)
            value = list_model[$urandom_range(list_model.size() - 1)];
         else if ($urandom_range(1))
            value = VALUE_W'($urandom_range(8) + 252);
         else
            value = VALUE_W'($urandom_range(255));
         send_word(op, value);
         if (op != OP_IGNORED) sent++;
      end
   endtask

   // rsp ready: random stalls, or a long hold when asked
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // compare each taken rsp word with the oldest owed one
   always @(posedge clock) begin
      rsp_word_type seen;
      rsp_word_type owed;
      if (!reset && rsp.valid && rsp.ready) begin
         seen.status      = status_type'(rsp.status);
         seen.item        = rsp.item;
         seen.last        = rsp.last;
         seen.entry_count = rsp.entry_count;
         if (due_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, %s %0d item %0d last %0d count %0d",
                     $time, "actual status", seen.status, seen.item, seen.last,
                     seen.entry_count);
         end else begin
            owed = due_words.pop_front();
            if (seen !== owed) begin
               error_count++;
               $display("%0t: mismatch, expected status %0d item %0d last %0d count %0d,",
                        $time, owed.status, owed.item, owed.last, owed.entry_count);
               $display("%0t: actual status %0d item %0d last %0d count %0d",
                        $time, seen.status, seen.item, seen.last, seen.entry_count);
            end
         end
      end
   end

   // watchdog on cycles with no word taken on either side
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset      = 1'b1;
      req.valid  = 1'b0;
      req.opcode = '0;
      req.value  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_cases;
      drain_words;
      test_input_stall;
      drain_words;
      steady = 1'b1;
      test_random_mix(80);
      steady = 1'b0;
      test_random_mix(240);
      drain_words;
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && due_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
